// ===== rtl/swqa_pkg.sv =====
`default_nettype none

package swqa_pkg;

    localparam int SpeedWidth = 7;
    localparam int CountWidth = 16;
    localparam int AmountWidth = 8;

    // Input commands.
    localparam logic [1:0] CMD_EDGE_A = 2'd0;
    localparam logic [1:0] CMD_EDGE_B = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_ACCEL_ENABLE = 2'd0;
    localparam logic [1:0] REG_SPEED_MIN    = 2'd1;
    localparam logic [1:0] REG_SPEED_MAX    = 2'd2;
    localparam logic [1:0] REG_PAUSE_TICKS  = 2'd3;

    // Register reset values.
    localparam logic [SpeedWidth-1:0] SPEED_MIN_RESET   = 7'd1;
    localparam logic [SpeedWidth-1:0] SPEED_MAX_RESET   = 7'd8;
    localparam logic [CountWidth-1:0] PAUSE_TICKS_RESET = 16'd100;

    typedef struct packed {
        logic                  accel_enable;
        logic [SpeedWidth-1:0] speed_min;
        logic [SpeedWidth-1:0] speed_max;
        logic [CountWidth-1:0] pause_ticks;
    } swqa_cfg_t;

    typedef struct packed {
        logic [SpeedWidth-1:0] speed;
        logic [CountWidth-1:0] idle_count;
    } swqa_speed_t;

endpackage

`default_nettype wire

// ===== rtl/swqa_accel.sv =====
`default_nettype none

module swqa_accel
    import swqa_pkg::*;
(
    input  wire swqa_cfg_t   cfg,
    input  wire              event_pending,
    input  wire swqa_speed_t cur,
    output swqa_speed_t      nxt
);

    always_comb
    begin
        nxt = cur;
        if (cfg.accel_enable)
        begin
            if (event_pending)
            begin
                nxt.idle_count = '0;
                // Speed is below a 7-bit maximum here, so the increment cannot wrap.
                if (cur.speed < cfg.speed_max)
                begin
                    nxt.speed = cur.speed + 7'd1;
                end
            end
            else if (cur.speed > cfg.speed_min)
            begin
                if (cur.idle_count > cfg.pause_ticks)
                begin
                    nxt.speed      = cur.speed - 7'd1;
                    nxt.idle_count = '0;
                end
                else if (cur.idle_count != '1)
                begin
                    nxt.idle_count = cur.idle_count + 16'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scroll_wheel_quadrature_accel_unit.sv =====
`default_nettype none

// Channel  Handshake             Payload
// -------  --------------------  ---------------------------------------
// in       in_valid / in_ready   command[1:0], pin_level
// out      out_valid / out_ready scroll_amount[7:0] (signed)
// cfg      cfg_valid / cfg_ready cfg_index[1:0], cfg_data[15:0]
//
// One item is taken per cycle while input ready is high. A tick with a pending
// event puts its report in the output register, or in the skid register if a
// report waits there. This two-entry buffer keeps input ready high while one
// report waits and drops it only while both entries are full. Reset clears all
// state but buffer data, loads register defaults, sets speed to min default.
module scroll_wheel_quadrature_accel_unit
    import swqa_pkg::*;
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire [1:0]                    command,
    input  wire                          pin_level,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic signed [AmountWidth-1:0] scroll_amount,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire [1:0]                    cfg_index,
    input  wire [CountWidth-1:0]         cfg_data
);

    swqa_cfg_t   cfg_reg;
    swqa_speed_t spd_reg;
    swqa_speed_t spd_next;
    logic        level_a_reg;
    logic        level_b_reg;
    logic        dir_down_reg;
    logic        pending_reg;

    logic                   out_valid_reg;
    logic [AmountWidth-1:0] out_data_reg;
    logic                   skid_valid_reg;
    logic [AmountWidth-1:0] skid_data_reg;

    logic                   in_xfer;
    logic                   is_tick;
    logic                   push;
    logic                   pop;
    logic [AmountWidth-1:0] report;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign in_xfer   = in_valid && in_ready;
    assign is_tick   = (command == CMD_TICK);
    assign push      = in_xfer && is_tick && pending_reg;
    assign pop       = out_valid_reg && out_ready;

    assign out_valid     = out_valid_reg;
    assign scroll_amount = out_data_reg;

    swqa_accel u_accel (
        .cfg           (cfg_reg),
        .event_pending (pending_reg),
        .cur           (spd_reg),
        .nxt           (spd_next)
    );

    // The report uses the speed after this tick's adjustment.
    always_comb
    begin
        if (dir_down_reg)
        begin
            report = AmountWidth'(8'd0 - {1'b0, spd_next.speed});
        end
        else
        begin
            report = {1'b0, spd_next.speed};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel_enable <= 1'b0;
            cfg_reg.speed_min    <= SPEED_MIN_RESET;
            cfg_reg.speed_max    <= SPEED_MAX_RESET;
            cfg_reg.pause_ticks  <= PAUSE_TICKS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ACCEL_ENABLE: cfg_reg.accel_enable <= cfg_data[0];
                REG_SPEED_MIN:    cfg_reg.speed_min    <= cfg_data[SpeedWidth-1:0];
                REG_SPEED_MAX:    cfg_reg.speed_max    <= cfg_data[SpeedWidth-1:0];
                REG_PAUSE_TICKS:  cfg_reg.pause_ticks  <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_a_reg        <= 1'b0;
            level_b_reg        <= 1'b0;
            dir_down_reg       <= 1'b0;
            pending_reg        <= 1'b0;
            spd_reg.speed      <= SPEED_MIN_RESET;
            spd_reg.idle_count <= '0;
        end
        else if (in_xfer)
        begin
            unique case (command)
                CMD_EDGE_A:
                begin
                    level_a_reg  <= pin_level;
                    dir_down_reg <= (pin_level != level_b_reg);
                    pending_reg  <= 1'b1;
                end
                CMD_EDGE_B:
                begin
                    level_b_reg  <= pin_level;
                    dir_down_reg <= (pin_level == level_a_reg);
                    pending_reg  <= 1'b1;
                end
                CMD_TICK:
                begin
                    spd_reg     <= spd_next;
                    pending_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Output buffer: a new report can only arrive while the skid entry is empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : report;
        end
        else if (!out_valid_reg)
        begin
            out_data_reg <= report;
        end
        if (!pop && out_valid_reg && push)
        begin
            skid_data_reg <= report;
        end
    end

endmodule

`default_nettype wire
